@@ src/md5kx_pkg.sv @@
// Package for the MD5 keyed rolling-key stream decrypt core.
// Holds the MD5 round constants, shift amounts and register indexes; no dependencies.
package md5kx_pkg;

	// Standard MD5 chaining value initializers.
	localparam logic [31:0] MD5_A0 = 32'h67452301;
	localparam logic [31:0] MD5_B0 = 32'hefcdab89;
	localparam logic [31:0] MD5_C0 = 32'h98badcfe;
	localparam logic [31:0] MD5_D0 = 32'h10325476;

	// Configuration register indexes.
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] CFG_INITIAL_KEY    = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_MESSAGE_LENGTH = 2'd1;

	// Padding words of a single-block MD5 of a four-byte message.
	localparam logic [31:0] PAD_WORD   = 32'h00000080;
	localparam logic [31:0] LENGTH_BITS = 32'd32;

	typedef logic [5:0] round_t;

	// Per-round additive constant.
	function automatic logic [31:0] md5_k(input round_t i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// Left-rotate amount, indexed by {quarter, round mod 4}.
	function automatic logic [4:0] md5_rot(input logic [3:0] sel);
		logic [4:0] r;
		case (sel)
			4'd0:  r = 5'd7;  4'd1:  r = 5'd12; 4'd2:  r = 5'd17; 4'd3:  r = 5'd22;
			4'd4:  r = 5'd5;  4'd5:  r = 5'd9;  4'd6:  r = 5'd14; 4'd7:  r = 5'd20;
			4'd8:  r = 5'd4;  4'd9:  r = 5'd11; 4'd10: r = 5'd16; 4'd11: r = 5'd23;
			4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; 4'd15: r = 5'd21;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

@@ src/md5_rolling_key_stream_decrypt_core.sv @@
// Top level of the MD5 keyed rolling-key stream decrypt core.
// Depends on md5kx_pkg for the round constants and register indexes.

// Each accepted transaction XORs the ciphertext word with the current rolling
// key and places the plaintext word and its valid byte count in the output
// register at once. The key then advances through one MD5 compression that a
// single shared round unit performs one round per clock, so the input is
// busy until the last round is done and a new word can be taken only then,
// provided the previous result has been taken or is taken in the same
// cycle. A start marker reloads the key and byte count from the registers,
// and register writes affect only the next start marker.
module md5_rolling_key_stream_decrypt_core
	import md5kx_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write channel.
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [31:0]        cfg_data,
	// Input channel.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               start_message,
	input  logic [31:0]        cipher_word,
	// Output channel.
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        plain_word,
	output logic [2:0]         valid_bytes
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic        state_q;
	round_t      round_q;
	logic [31:0] initial_key_q;
	logic [31:0] message_length_q;
	logic [31:0] rolling_key_q;
	logic [31:0] bytes_left_q;
	logic [31:0] a_q, b_q, c_q, d_q;
	logic        out_valid_q;
	logic [31:0] plain_word_q;
	logic [2:0]  valid_bytes_q;

	logic        in_fire;
	logic        last_round;
	logic [31:0] key_eff;
	logic [31:0] left_eff;
	logic [2:0]  valid_eff;
	logic [31:0] f_val;
	logic [3:0]  g_idx;
	logic [31:0] m_val;
	logic [31:0] sum_val;
	logic [4:0]  rot_amt;
	logic [63:0] rot_wide;
	logic [31:0] b_next;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire   = in_valid && in_ready;
	assign last_round = (round_q == round_t'(63));

	// Key and byte count seen by this word, after an optional reload.
	always_comb begin
		key_eff  = start_message ? initial_key_q : rolling_key_q;
		left_eff = start_message ? message_length_q : bytes_left_q;
		if (left_eff >= 32'd4) begin
			valid_eff = 3'd4;
		end else begin
			valid_eff = left_eff[2:0];
		end
	end

	// Round function and message word index for the current round.
	always_comb begin
		case (round_q[5:4])
			2'd0: begin
				f_val = (b_q & c_q) | (~b_q & d_q);
				g_idx = round_q[3:0];
			end
			2'd1: begin
				f_val = (d_q & b_q) | (~d_q & c_q);
				g_idx = 4'(round_q[3:0] * 4'd5 + 4'd1);
			end
			2'd2: begin
				f_val = b_q ^ c_q ^ d_q;
				g_idx = 4'(round_q[3:0] * 4'd3 + 4'd5);
			end
			default: begin
				f_val = c_q ^ (b_q | ~d_q);
				g_idx = 4'(round_q[3:0] * 4'd7);
			end
		endcase
	end

	// The padded block holds the key, the pad byte and the bit length.
	always_comb begin
		case (g_idx)
			4'd0:    m_val = rolling_key_q;
			4'd1:    m_val = PAD_WORD;
			4'd14:   m_val = LENGTH_BITS;
			default: m_val = 32'd0;
		endcase
	end

	// Shared round datapath: add chain, rotate, add.
	always_comb begin
		sum_val  = a_q + f_val + md5_k(round_q) + m_val;
		rot_amt  = md5_rot({round_q[5:4], round_q[1:0]});
		rot_wide = {sum_val, sum_val} << rot_amt;
		b_next   = b_q + rot_wide[63:32];
	end

	// Control, configuration and key state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			round_q          <= '0;
			initial_key_q    <= '0;
			message_length_q <= '0;
			rolling_key_q    <= '0;
			bytes_left_q     <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_INITIAL_KEY) begin
					initial_key_q <= cfg_data;
				end else if (cfg_index == CFG_MESSAGE_LENGTH) begin
					message_length_q <= cfg_data;
				end
			end
			if (in_fire) begin
				out_valid_q   <= 1'b1;
				rolling_key_q <= key_eff;
				bytes_left_q  <= left_eff - {29'd0, valid_eff};
				state_q       <= ST_RUN;
				round_q       <= '0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_RUN) begin
				round_q <= round_q + round_t'(1);
				if (last_round) begin
					// Final D equals C before the last round.
					rolling_key_q <= rolling_key_q ^ (c_q + MD5_D0);
					state_q       <= ST_IDLE;
					round_q       <= '0;
				end
			end
		end
	end

	// Result payload and MD5 working registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			plain_word_q  <= cipher_word ^ key_eff;
			valid_bytes_q <= valid_eff;
			a_q <= MD5_A0;
			b_q <= MD5_B0;
			c_q <= MD5_C0;
			d_q <= MD5_D0;
		end else if (state_q == ST_RUN) begin
			a_q <= d_q;
			b_q <= b_next;
			c_q <= b_q;
			d_q <= c_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign plain_word  = plain_word_q;
	assign valid_bytes = valid_bytes_q;

	// An accepted transaction starts the compression and fills the output.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_RUN && out_valid)
		else $error("accepted transaction did not start the key update");

	// No new transaction while the round unit is busy.
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> !in_ready)
		else $error("input ready during key update");

	// The round counter rests at zero when idle.
	a_idle_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> round_q == '0)
		else $error("round counter not cleared while idle");

	// The last round returns the block to idle.
	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && last_round |=> state_q == ST_IDLE)
		else $error("compression did not finish after the last round");

endmodule

@@ sim/tb_md5_rolling_key_stream_decrypt_core.sv @@
// Testbench for md5_rolling_key_stream_decrypt_core: predicts each plaintext word and byte count
// from its own MD5 key schedule and checks every output transaction against it.
// Depends on md5kx_pkg and the core RTL only.
module tb_md5_rolling_key_stream_decrypt_core;
	import md5kx_pkg::*;

	localparam int HALF_PERIOD     = 4;
	localparam int RESET_CYCLES    = 11;
	localparam int KEY_LATENCY     = 70;
	localparam int CYCLE_LIMIT     = 1200000;
	localparam int RANDOM_WORDS    = 1220;
	localparam int IDLE_PERCENT    = 11;
	localparam int HOLD_OFF_CYCLES = 400;

	// Register indexes that decode to nothing in the core.
	localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

	// MD5 chaining start values, additive constants and shift amounts.
	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;
	localparam logic [31:0] ROUND_ADD [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int ROUND_SHIFT [16] = '{
		7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
	};

	typedef struct packed {
		logic [31:0] plain;
		logic [2:0]  nbytes;
	} plain_result_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               start_message;
	logic [31:0]        cipher_word;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [31:0]        plain_word;
	logic [2:0]         valid_bytes;

	// Shadow registers and running decrypt state of the predictor.
	logic [31:0] shadow_key;
	logic [31:0] shadow_length;
	logic [31:0] key_now;
	logic [31:0] bytes_remaining;

	plain_result_t plain_results_due [$];
	int err_count   = 0;
	int words_sent  = 0;
	int cycle_count = 0;
	bit tx_steady   = 1'b0;
	bit rx_steady   = 1'b0;
	int hold_asked  = 0;
	int hold_served = 0;
	int hold_left   = 0;

	always #HALF_PERIOD clk = ~clk;

	md5_rolling_key_stream_decrypt_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.start_message (start_message),
		.cipher_word   (cipher_word),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.plain_word    (plain_word),
		.valid_bytes   (valid_bytes)
	);

	// Final D chaining value of MD5 over the four little-endian bytes of v.
	function automatic logic [31:0] md5_tail_of(input logic [31:0] v);
		logic [31:0] msg [16];
		logic [31:0] a, b, c, d, f, t, sum;
		int i, g, s;
		for (i = 0; i < 16; i++) msg[i] = 32'h0;
		msg[0]  = v;
		msg[1]  = 32'h80;
		msg[14] = 32'd32;
		a = IV_A; b = IV_B; c = IV_C; d = IV_D;
		for (i = 0; i < 64; i++) begin
			case (i / 16)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * i + 1) % 16;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) % 16;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) % 16;
				end
			endcase
			s   = ROUND_SHIFT[(i / 16) * 4 + i % 4];
			sum = a + f + ROUND_ADD[i] + msg[g];
			t   = d;
			d   = c;
			c   = b;
			b   = b + ((sum << s) | (sum >> (32 - s)));
			a   = t;
		end
		return d + IV_D;
	endfunction

	// Work out the result of one accepted word and advance the key.
	task automatic predict_plain(input bit start, input logic [31:0] word);
		plain_result_t r;
		logic [31:0] nb;
		if (start) begin
			key_now         = shadow_key;
			bytes_remaining = shadow_length;
		end
		nb       = (bytes_remaining >= 32'd4) ? 32'd4 : bytes_remaining;
		r.plain  = word ^ key_now;
		r.nbytes = nb[2:0];
		plain_results_due.push_back(r);
		key_now         = key_now ^ md5_tail_of(key_now);
		bytes_remaining = bytes_remaining - nb;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
		err_count++;
	endtask

	// Offer one word and hold it until the transaction completes.
	task automatic send_word(input bit start, input logic [31:0] word);
		while (!tx_steady && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 80)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		start_message <= start;
		cipher_word   <= word;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_plain(start, word);
		words_sent++;
	endtask

	// One register write; valid stays high for a following write.
	task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_INITIAL_KEY:    shadow_key    = data;
			CFG_MESSAGE_LENGTH: shadow_length = data;
			default: ;
		endcase
	endtask

	// Wait for the core to go idle, then program both registers.
	task automatic load_registers(input logic [31:0] key, input logic [31:0] len,
			input bit with_spare);
		in_valid <= 1'b0;
		while (plain_results_due.size() != 0) @(posedge clk);
		repeat (KEY_LATENCY) @(posedge clk);
		if (with_spare) cfg_put(CFG_SPARE_2, ~key);
		cfg_put(CFG_INITIAL_KEY, key);
		cfg_put(CFG_MESSAGE_LENGTH, len);
		if (with_spare) cfg_put(CFG_SPARE_3, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// Without any start marker the key starts at zero and no byte is valid.
	task automatic test_no_start_after_reset;
		send_word(1'b0, 32'h00000000);
		send_word(1'b0, 32'hffffffff);
		send_word(1'b0, 32'ha5a5a5a5);
	endtask

	// Short messages end in a partial word and then saturate at zero.
	task automatic test_short_messages;
		load_registers(32'hffffffff, 32'd5, 1'b0);
		send_word(1'b1, 32'h00000000);
		send_word(1'b0, 32'hffffffff);
		send_word(1'b0, 32'h12345678);
		load_registers(32'h00000000, 32'd0, 1'b1);
		send_word(1'b1, 32'hffffffff);
		load_registers(32'h80000001, 32'd3, 1'b1);
		send_word(1'b1, 32'h5a5a5a5a);
		send_word(1'b0, 32'h00000001);
		load_registers(32'h0000ffff, 32'd2, 1'b0);
		send_word(1'b1, 32'h80000000);
	endtask

	// The largest length leaves every word fully valid.
	task automatic test_max_length;
		load_registers(32'h12345678, 32'hffffffff, 1'b0);
		send_word(1'b1, 32'hdeadbeef);
		send_word(1'b0, 32'h0f0f0f0f);
		send_word(1'b0, 32'hf0f0f0f0);
	endtask

	// New register values wait for the next start marker.
	task automatic test_deferred_config;
		load_registers(32'hdeadbeef, 32'd2, 1'b0);
		send_word(1'b0, 32'hcafef00d);
		send_word(1'b0, 32'h00ff00ff);
		send_word(1'b1, 32'hff00ff00);
		send_word(1'b0, 32'h11111111);
	endtask

	// A start marker in the middle of a message reloads key and count.
	task automatic test_restart_midway;
		send_word(1'b1, 32'h76543210);
		send_word(1'b1, 32'h76543210);
	endtask

	// The receiver stalls for a long stretch while words keep coming.
	task automatic test_output_hold_off;
		int k;
		load_registers($urandom, 32'd17, 1'b0);
		tx_steady = 1'b1;
		hold_asked++;
		for (k = 0; k < 6; k++) send_word(k == 0, $urandom);
		tx_steady = 1'b0;
	endtask

	// Random messages, mostly well formed, some with stray start markers.
	task automatic test_random_messages;
		int target, nwords, k;
		logic [31:0] key, len;
		bit noisy;
		target = words_sent + RANDOM_WORDS;
		while (words_sent < target) begin
			tx_steady = (words_sent > target - 900) && (words_sent < target - 650);
			rx_steady = tx_steady;
			if ($urandom_range(9) < 7) begin
				case ($urandom_range(9))
					0:       key = 32'h00000000;
					1:       key = 32'hffffffff;
					default: key = $urandom;
				endcase
				case ($urandom_range(19))
					0:       len = 32'd0;
					1:       len = 32'hffffffff;
					2:       len = $urandom;
					3:       len = $urandom_range(1, 3);
					default: len = $urandom_range(4, 48);
				endcase
				load_registers(key, len, $urandom_range(3) == 0);
			end
			noisy = ($urandom_range(9) == 0);
			if (shadow_length > 32'd48)
				nwords = $urandom_range(1, 12);
			else
				nwords = (shadow_length + 3) / 4 + $urandom_range(0, 2);
			if (nwords == 0) nwords = 1;
			for (k = 0; k < nwords; k++)
				send_word(noisy ? 1'($urandom_range(1)) : (k == 0), $urandom);
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Receiver: random stalls plus long hold-offs on request.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_served + 1;
			hold_left   <= HOLD_OFF_CYCLES - 1;
			out_ready   <= 1'b0;
		end else if (!rx_steady && $urandom_range(99) < IDLE_PERCENT) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each output transaction with the oldest expected result.
	always @(posedge clk) begin
		plain_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (plain_results_due.size() == 0) begin
				report_mismatch("unexpected result, plain_word", plain_word, 32'h0);
			end else begin
				want = plain_results_due.pop_front();
				if (plain_word !== want.plain)
					report_mismatch("plain_word", plain_word, want.plain);
				if (valid_bytes !== want.nbytes)
					report_mismatch("valid_bytes", {29'h0, valid_bytes}, {29'h0, want.nbytes});
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_index       = CFG_INITIAL_KEY;
		cfg_data        = 32'h0;
		in_valid        = 1'b0;
		start_message   = 1'b0;
		cipher_word     = 32'h0;
		shadow_key      = 32'h0;
		shadow_length   = 32'h0;
		key_now         = 32'h0;
		bytes_remaining = 32'h0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_no_start_after_reset;
		test_short_messages;
		test_max_length;
		test_deferred_config;
		test_restart_midway;
		test_output_hold_off;
		test_random_messages;

		// Drain the last results and let the key schedule settle.
		in_valid <= 1'b0;
		while (plain_results_due.size() != 0) @(posedge clk);
		repeat (KEY_LATENCY) @(posedge clk);
		if (err_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/md5kx_pkg.sv
src/md5_rolling_key_stream_decrypt_core.sv
sim/tb_md5_rolling_key_stream_decrypt_core.sv
